[rtl/core/u3gm_pkg.sv]
// ----------------------------------------------------------------------------
// u3gm_pkg
// Shared types, constants and fixed-point helpers of the U3 gate matrix unit.
// ----------------------------------------------------------------------------
package u3gm_pkg;

  // Sample format: signed, one integer bit, the rest fraction
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned FRAC_BITS    = SAMPLE_WIDTH - 1;

  typedef logic signed [SAMPLE_WIDTH-1:0]   sample_t;
  typedef logic signed [2*SAMPLE_WIDTH-1:0] prod_t;   // exact product
  typedef logic signed [2*SAMPLE_WIDTH:0]   wide_t;   // product with sign applied
  typedef logic signed [SAMPLE_WIDTH:0]     sum_t;    // sum of two samples

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam wide_t   WIDE_MAX   = wide_t'(SAMPLE_MAX);
  localparam wide_t   WIDE_MIN   = wide_t'(SAMPLE_MIN);
  localparam sum_t    SUM_MAX    = sum_t'(SAMPLE_MAX);
  localparam sum_t    SUM_MIN    = sum_t'(SAMPLE_MIN);
  localparam wide_t   HALF_LSB   = wide_t'(1) <<< (FRAC_BITS - 1);

  // Command codes of the input beat
  localparam logic [1:0] CMD_GATE     = 2'd0;
  localparam logic [1:0] CMD_INVERSE  = 2'd1;
  localparam logic [1:0] CMD_DERIV    = 2'd2;

  // Derivative angle codes
  localparam logic [1:0] DIDX_THETA  = 2'd0;
  localparam logic [1:0] DIDX_PHI    = 2'd1;
  localparam logic [1:0] DIDX_LAMBDA = 2'd2;

  // Matrix to build, decoded once at the input
  typedef enum logic [2:0] {
    MODE_GATE,
    MODE_INVERSE,
    MODE_D_THETA,
    MODE_D_PHI,
    MODE_D_LAMBDA,
    MODE_ZERO
  } mode_e;

  // The six trig values of one beat
  typedef struct packed {
    sample_t st;   // sin(theta/2)
    sample_t ct;   // cos(theta/2)
    sample_t sp;   // sin(phi)
    sample_t cp;   // cos(phi)
    sample_t sl;   // sin(lambda)
    sample_t cl;   // cos(lambda)
  } trig_t;

  // One result beat, row-major
  typedef struct packed {
    sample_t m00_re;
    sample_t m00_im;
    sample_t m01_re;
    sample_t m01_im;
    sample_t m10_re;
    sample_t m10_im;
    sample_t m11_re;
    sample_t m11_im;
  } matrix_t;

  function automatic mode_e decode_mode(logic [1:0] cmd, logic [1:0] didx);
    mode_e m;
    m = MODE_ZERO;
    case (cmd)
      CMD_GATE:    m = MODE_GATE;
      CMD_INVERSE: m = MODE_INVERSE;
      CMD_DERIV: begin
        case (didx)
          DIDX_THETA:  m = MODE_D_THETA;
          DIDX_PHI:    m = MODE_D_PHI;
          DIDX_LAMBDA: m = MODE_D_LAMBDA;
          default:     m = MODE_ZERO;
        endcase
      end
      default:     m = MODE_ZERO;
    endcase
    return m;
  endfunction

  // Apply sign, round half up to the fraction width, saturate
  function automatic sample_t mul_round(prod_t p, logic neg);
    wide_t   x;
    wide_t   r;
    sample_t res;
    x = neg ? -wide_t'(p) : wide_t'(p);
    r = (x + HALF_LSB) >>> FRAC_BITS;
    if (r > WIDE_MAX) begin
      res = SAMPLE_MAX;
    end else if (r < WIDE_MIN) begin
      res = SAMPLE_MIN;
    end else begin
      res = r[SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

  function automatic sample_t sat_sum(sum_t s);
    sample_t res;
    if (s > SUM_MAX) begin
      res = SAMPLE_MAX;
    end else if (s < SUM_MIN) begin
      res = SAMPLE_MIN;
    end else begin
      res = s[SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

  // Saturating a + b, or a - b when sub is set
  function automatic sample_t add_sat(sample_t a, sample_t b, logic sub);
    sum_t s;
    s = sub ? (sum_t'(a) - sum_t'(b)) : (sum_t'(a) + sum_t'(b));
    return sat_sum(s);
  endfunction

  function automatic sample_t neg_sat(sample_t a);
    sum_t s;
    s = -sum_t'(a);
    return sat_sum(s);
  endfunction

endpackage

[rtl/core/u3gm_in_if.sv]
// ----------------------------------------------------------------------------
// u3gm_in_if
// Input channel: command, derivative index and the six trig samples.
// ----------------------------------------------------------------------------
interface u3gm_in_if
  import u3gm_pkg::*;
();

  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [1:0] deriv_index;
  sample_t    sin_half_theta;
  sample_t    cos_half_theta;
  sample_t    sin_phi_in;
  sample_t    cos_phi_in;
  sample_t    sin_lambda_in;
  sample_t    cos_lambda_in;

  modport source (
    output valid, command, deriv_index, sin_half_theta, cos_half_theta,
           sin_phi_in, cos_phi_in, sin_lambda_in, cos_lambda_in,
    input  ready
  );

  modport sink (
    input  valid, command, deriv_index, sin_half_theta, cos_half_theta,
           sin_phi_in, cos_phi_in, sin_lambda_in, cos_lambda_in,
    output ready
  );

endinterface

[rtl/core/u3gm_out_if.sv]
// ----------------------------------------------------------------------------
// u3gm_out_if
// Output channel: the four complex matrix entries, row-major.
// ----------------------------------------------------------------------------
interface u3gm_out_if
  import u3gm_pkg::*;
();

  logic    valid;
  logic    ready;
  sample_t m00_re;
  sample_t m00_im;
  sample_t m01_re;
  sample_t m01_im;
  sample_t m10_re;
  sample_t m10_im;
  sample_t m11_re;
  sample_t m11_im;

  modport source (
    output valid, m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im,
    input  ready
  );

  modport sink (
    input  valid, m00_re, m00_im, m01_re, m01_im, m10_re, m10_im, m11_re, m11_im,
    output ready
  );

endinterface

[rtl/core/u3gm_angle_sum.sv]
// ----------------------------------------------------------------------------
// u3gm_angle_sum
// Two pipeline stages: the four angle-sum products, then rounding and the
// saturated sum and difference giving sin and cos of phi plus lambda.
// ----------------------------------------------------------------------------
module u3gm_angle_sum
  import u3gm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  mode_e   mode_i,
  input  trig_t   trig_i,
  output logic    valid_o,
  input  logic    ready_i,
  output mode_e   mode_o,
  output trig_t   trig_o,
  output sample_t spl_o,
  output sample_t cpl_o
);

  // Stage 1: exact products
  logic  s1_valid_q;
  mode_e s1_mode_q;
  trig_t s1_trig_q;
  prod_t p_spcl_q, p_cpsl_q, p_cpcl_q, p_spsl_q;

  // Stage 2: angle sum
  logic    s2_valid_q;
  mode_e   s2_mode_q;
  trig_t   s2_trig_q;
  sample_t spl_q, cpl_q;
  sample_t spl_d, cpl_d;

  logic s1_ready, s2_ready;

  // Per-stage ready: a stage loads when empty or when it drains
  assign s2_ready = !s2_valid_q || ready_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign ready_o  = s1_ready;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (s1_ready && valid_i) begin
      s1_mode_q <= mode_i;
      s1_trig_q <= trig_i;
      p_spcl_q  <= prod_t'(trig_i.sp) * prod_t'(trig_i.cl);
      p_cpsl_q  <= prod_t'(trig_i.cp) * prod_t'(trig_i.sl);
      p_cpcl_q  <= prod_t'(trig_i.cp) * prod_t'(trig_i.cl);
      p_spsl_q  <= prod_t'(trig_i.sp) * prod_t'(trig_i.sl);
    end
  end

  // sin(p+l) = sp*cl + cp*sl, cos(p+l) = cp*cl - sp*sl; products rounded first
  always_comb begin
    spl_d = add_sat(mul_round(p_spcl_q, 1'b0), mul_round(p_cpsl_q, 1'b0), 1'b0);
    cpl_d = add_sat(mul_round(p_cpcl_q, 1'b0), mul_round(p_spsl_q, 1'b0), 1'b1);
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_mode_q <= s1_mode_q;
      s2_trig_q <= s1_trig_q;
      spl_q     <= spl_d;
      cpl_q     <= cpl_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign mode_o  = s2_mode_q;
  assign trig_o  = s2_trig_q;
  assign spl_o   = spl_q;
  assign cpl_o   = cpl_q;

  // A beat loaded into stage 1 reaches stage 2 as soon as stage 2 drains
  a_s1_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s2_ready) |=> s2_valid_q)
    else $error("angle sum: stage 1 beat lost");

  // A stalled stage 2 keeps its beat and its angle sum
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !ready_i) |=> (s2_valid_q && $stable(spl_q) && $stable(cpl_q)))
    else $error("angle sum: stalled stage 2 changed");

  // Stage 1 only fills when upstream offers a beat
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_ready && !valid_i) |=> !s1_valid_q)
    else $error("angle sum: stage 1 filled without a beat");

endmodule

[rtl/core/u3gm_entry_mul.sv]
// ----------------------------------------------------------------------------
// u3gm_entry_mul
// Two pipeline stages: operand selection and the six entry products, then
// sign, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module u3gm_entry_mul
  import u3gm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  mode_e   mode_i,
  input  trig_t   trig_i,
  input  sample_t spl_i,
  input  sample_t cpl_i,
  output logic    valid_o,
  input  logic    ready_i,
  output matrix_t res_o
);

  // Products feed m01_re, m01_im, m10_re, m10_im, m11_re, m11_im
  localparam int unsigned NPROD = 6;

  sample_t opa [NPROD];
  sample_t opb [NPROD];
  logic    neg_d [NPROD];
  sample_t m0_d;

  // Stage 3: exact products
  logic    s3_valid_q;
  mode_e   s3_mode_q;
  prod_t   prod_q [NPROD];
  logic    neg_q [NPROD];
  sample_t m0_q;

  // Stage 4: output register
  logic    s4_valid_q;
  matrix_t res_q;
  matrix_t res_d;

  logic s3_ready, s4_ready;

  assign s4_ready = !s4_valid_q || ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign ready_o  = s3_ready;

  // Operand selection per matrix kind; a zero operand gives a zero entry
  always_comb begin
    for (int k = 0; k < NPROD; k++) begin
      opa[k]   = '0;
      opb[k]   = '0;
      neg_d[k] = 1'b0;
    end
    m0_d = '0;
    case (mode_i)
      MODE_GATE: begin
        m0_d = trig_i.ct;
        opa[0] = trig_i.st; opb[0] = trig_i.cl; neg_d[0] = 1'b1;
        opa[1] = trig_i.st; opb[1] = trig_i.sl; neg_d[1] = 1'b1;
        opa[2] = trig_i.st; opb[2] = trig_i.cp;
        opa[3] = trig_i.st; opb[3] = trig_i.sp;
        opa[4] = trig_i.ct; opb[4] = cpl_i;
        opa[5] = trig_i.ct; opb[5] = spl_i;
      end
      MODE_INVERSE: begin
        m0_d = trig_i.ct;
        opa[0] = trig_i.st; opb[0] = trig_i.cp;
        opa[1] = trig_i.st; opb[1] = trig_i.sp; neg_d[1] = 1'b1;
        opa[2] = trig_i.st; opb[2] = trig_i.cl; neg_d[2] = 1'b1;
        opa[3] = trig_i.st; opb[3] = trig_i.sl;
        opa[4] = trig_i.ct; opb[4] = cpl_i;
        opa[5] = trig_i.ct; opb[5] = spl_i;    neg_d[5] = 1'b1;
      end
      MODE_D_THETA: begin
        m0_d = neg_sat(trig_i.st);
        opa[0] = trig_i.ct; opb[0] = trig_i.cl; neg_d[0] = 1'b1;
        opa[1] = trig_i.ct; opb[1] = trig_i.sl; neg_d[1] = 1'b1;
        opa[2] = trig_i.ct; opb[2] = trig_i.cp;
        opa[3] = trig_i.ct; opb[3] = trig_i.sp;
        opa[4] = trig_i.st; opb[4] = cpl_i;    neg_d[4] = 1'b1;
        opa[5] = trig_i.st; opb[5] = spl_i;    neg_d[5] = 1'b1;
      end
      MODE_D_PHI: begin
        opa[2] = trig_i.st; opb[2] = trig_i.sp; neg_d[2] = 1'b1;
        opa[3] = trig_i.st; opb[3] = trig_i.cp;
        opa[4] = trig_i.ct; opb[4] = spl_i;    neg_d[4] = 1'b1;
        opa[5] = trig_i.ct; opb[5] = cpl_i;
      end
      MODE_D_LAMBDA: begin
        opa[0] = trig_i.st; opb[0] = trig_i.sl;
        opa[1] = trig_i.st; opb[1] = trig_i.cl; neg_d[1] = 1'b1;
        opa[4] = trig_i.ct; opb[4] = spl_i;    neg_d[4] = 1'b1;
        opa[5] = trig_i.ct; opb[5] = cpl_i;
      end
      default: begin
        m0_d = '0;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_valid_q <= valid_i;
      end
      if (s4_ready) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage 3 payload: one multiplier per entry but m00
  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      s3_mode_q <= mode_i;
      m0_q      <= m0_d;
      for (int k = 0; k < NPROD; k++) begin
        prod_q[k] <= prod_t'(opa[k]) * prod_t'(opb[k]);
        neg_q[k]  <= neg_d[k];
      end
    end
  end

  // Sign, round and saturate
  always_comb begin
    res_d.m00_re = m0_q;
    res_d.m00_im = '0;
    res_d.m01_re = mul_round(prod_q[0], neg_q[0]);
    res_d.m01_im = mul_round(prod_q[1], neg_q[1]);
    res_d.m10_re = mul_round(prod_q[2], neg_q[2]);
    res_d.m10_im = mul_round(prod_q[3], neg_q[3]);
    res_d.m11_re = mul_round(prod_q[4], neg_q[4]);
    res_d.m11_im = mul_round(prod_q[5], neg_q[5]);
  end

  // Stage 4 payload
  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign res_o   = res_q;

  // A beat in stage 3 moves to the output once it has room
  a_s3_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s4_ready) |=> s4_valid_q)
    else $error("entry mul: stage 3 beat lost");

  // A held result keeps its payload
  a_s4_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && !ready_i) |=> (s4_valid_q && $stable(res_q)))
    else $error("entry mul: stalled result changed");

  // Zero matrix: every product and the diagonal entry are zero
  a_zero_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_mode_q == MODE_ZERO) |->
      (m0_q == '0 && prod_q[0] == '0 && prod_q[1] == '0 && prod_q[2] == '0 &&
       prod_q[3] == '0 && prod_q[4] == '0 && prod_q[5] == '0))
    else $error("entry mul: zero matrix carries a non-zero term");

  // Phi derivative leaves the top row empty
  a_dphi_row0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_mode_q == MODE_D_PHI) |->
      (m0_q == '0 && prod_q[0] == '0 && prod_q[1] == '0))
    else $error("entry mul: phi derivative top row not zero");

endmodule

[rtl/core/u3_gate_matrix_unit_top.sv]
// ----------------------------------------------------------------------------
// u3_gate_matrix_unit_top
// U3 single-qubit gate matrix unit: builds the gate matrix, its inverse or a
// derivative by one angle from the sines and cosines of the three angles.
//
//   channel | modport | beat
//   --------+---------+--------------------------------------------------
//   in_i    | sink    | command, deriv_index, six Q1.15 trig samples
//   out_o   | source  | m00..m11, real and imaginary, Q1.15
//
// One beat per cycle sustained while out_o is ready; pipeline stages from
// accept: angle-sum products, angle sum, entry products, round and saturate.
// Each stage has its own valid bit and takes a new beat whenever it is empty
// or draining, so bubbles collapse and a stall holds every beat in place.
// Reset clears the valid bits only; the payload registers are not reset.
// ----------------------------------------------------------------------------
module u3_gate_matrix_unit_top
  import u3gm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  u3gm_in_if.sink           in_i,
  u3gm_out_if.source        out_o
);

  mode_e   in_mode;
  trig_t   in_trig;
  logic    as_valid;
  logic    em_ready;
  mode_e   as_mode;
  trig_t   as_trig;
  sample_t as_spl;
  sample_t as_cpl;
  matrix_t res;

  // Decode the command once at the input
  assign in_mode    = decode_mode(in_i.command, in_i.deriv_index);
  assign in_trig.st = in_i.sin_half_theta;
  assign in_trig.ct = in_i.cos_half_theta;
  assign in_trig.sp = in_i.sin_phi_in;
  assign in_trig.cp = in_i.cos_phi_in;
  assign in_trig.sl = in_i.sin_lambda_in;
  assign in_trig.cl = in_i.cos_lambda_in;

  u3gm_angle_sum u_angle_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_mode),
    .trig_i  (in_trig),
    .valid_o (as_valid),
    .ready_i (em_ready),
    .mode_o  (as_mode),
    .trig_o  (as_trig),
    .spl_o   (as_spl),
    .cpl_o   (as_cpl)
  );

  u3gm_entry_mul u_entry_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (as_valid),
    .ready_o (em_ready),
    .mode_i  (as_mode),
    .trig_i  (as_trig),
    .spl_i   (as_spl),
    .cpl_i   (as_cpl),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  // Result beat
  assign out_o.m00_re = res.m00_re;
  assign out_o.m00_im = res.m00_im;
  assign out_o.m01_re = res.m01_re;
  assign out_o.m01_im = res.m01_im;
  assign out_o.m10_re = res.m10_re;
  assign out_o.m10_im = res.m10_im;
  assign out_o.m11_re = res.m11_re;
  assign out_o.m11_im = res.m11_im;

endmodule
